// ----- src/crchd_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// crchd_pkg
// Shared types, constants and table functions for the CRC-checked hash
// command decoder: CRC-16-CCITT byte step, command hash table and pulse pairs.
// ---------------------------------------------------------------------------
package crchd_pkg;

    localparam int NUM_COMMANDS_DEF = 5;
    localparam int HASH_BYTES       = 20;
    localparam int MESSAGE_BYTES    = 22;
    localparam int CMD_ROWS         = 16;
    localparam int DEF_ROWS         = 5;
    localparam int ROW_W            = $clog2(CMD_ROWS);
    localparam int POS_W            = 5;

    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [7:0]  BYTE_INVERT = 8'hFF;
    localparam logic [14:0] PULSE_RESET = 15'd1200;
    localparam logic [14:0] PULSE_1255  = 15'd1255;
    localparam logic [14:0] PULSE_1260  = 15'd1260;
    localparam logic [14:0] PULSE_1140  = 15'd1140;
    localparam logic [14:0] PULSE_1150  = 15'd1150;

    typedef enum logic [1:0] {
        STATUS_PLAIN   = 2'd0,
        STATUS_FLIPPED = 2'd1,
        STATUS_FAIL    = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] plain;
        logic [15:0] flipped;
    } crc_pair_t;

    localparam logic [8*HASH_BYTES-1:0] CMD_HASH_ROW [DEF_ROWS] = '{
        160'h6cf4cc48c2a7ce38d1f8f2b8873e9bf69f82669a,
        160'h652190acb8e304a9b402c52cb6c0df4385b5cd0f,
        160'h35c2fe58bb0f6b424b4c50ae8f64e237583ae86b,
        160'h580272ac43a667bc5c1d5d4c801c33024025a31c,
        160'h6585db71423ff065ce890123935420fae5b1d148
    };

    // One CRC-16-CCITT byte step, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // Hash byte at a digest position; rows past the defined commands are zero.
    function automatic logic [7:0] cmd_hash_byte(input logic [ROW_W-1:0] row,
                                                 input logic [POS_W-1:0] pos);
        logic [8*HASH_BYTES-1:0] r;
        logic [7:0]              v;
        v = 8'h00;
        if (row < ROW_W'(DEF_ROWS) && pos < POS_W'(HASH_BYTES)) begin
            r = CMD_HASH_ROW[3'(row)];
            r = r >> (8 * (HASH_BYTES - 1 - int'(pos)));
            v = r[7:0];
        end
        return v;
    endfunction

    function automatic logic [14:0] cmd_steer(input logic [ROW_W-1:0] row);
        logic [14:0] p;
        case (row)
            ROW_W'(2): p = PULSE_1260;
            ROW_W'(3): p = PULSE_1140;
            default:   p = PULSE_RESET;
        endcase
        return p;
    endfunction

    function automatic logic [14:0] cmd_motor(input logic [ROW_W-1:0] row);
        logic [14:0] p;
        case (row)
            ROW_W'(1), ROW_W'(2), ROW_W'(3): p = PULSE_1255;
            ROW_W'(4):                       p = PULSE_1150;
            default:                         p = PULSE_RESET;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ----- src/crc_checked_hash_command_decoder_core.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// crc_checked_hash_command_decoder_core
// Decodes CRC-checked 22-byte hash commands carried in groups of three
// eight-byte frames into held steering and motor pulse widths.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / frame_data) takes one frame per
//   request. Every third accepted frame closes a message and yields one
//   output request (out_valid / out_stall) with check_status,
//   command_found, command_index and the held steering_pulse/motor_pulse.
//   Frames one and two of a group produce no output request.
//   Timing: a closing frame sits in the input register and the result
//   register loads from it, raising the output request; the frame waits
//   there while an older result stalls. Throughput: one frame per cycle
//   unless a closing frame waits; the CRC of a frame's message bytes and
//   the hash byte compares are done in one pass between the two registers.
//   Receiver stall: the result register holds; a closing frame waits in the
//   input register and in_stall rises, while non-closing frames still flow.
//   Reset: group phase and CRCs clear, match flags all set, both held pulses
//   return to 1200, and no request is pending on either side.
// ---------------------------------------------------------------------------
module crc_checked_hash_command_decoder_core #(
    parameter int NUM_COMMANDS = crchd_pkg::NUM_COMMANDS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] frame_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       check_status,
    output logic             command_found,
    output logic [2:0]       command_index,
    output logic [14:0]      steering_pulse,
    output logic [14:0]      motor_pulse
);
    import crchd_pkg::*;

    localparam logic [NUM_COMMANDS-1:0] MATCH_ALL = '1;

    // Input register.
    logic        in_valid_reg;
    logic [63:0] in_data_reg;

    // Running message state.
    logic [1:0]              phase_reg, phase_next;
    crc_pair_t               crc_reg;
    logic [NUM_COMMANDS-1:0] match_plain_reg;
    logic [NUM_COMMANDS-1:0] match_flipped_reg;
    logic [14:0]             steering_hold_reg;
    logic [14:0]             motor_hold_reg;

    // Result register.
    logic        out_valid_reg;
    status_t     status_reg;
    logic        found_reg;
    logic [2:0]  index_reg;

    // Combinational results.
    crc_pair_t               crc_upd;
    logic [NUM_COMMANDS-1:0] match_plain_upd;
    logic [NUM_COMMANDS-1:0] match_flipped_upd;
    status_t                 sel_status;
    logic                    sel_found;
    logic [2:0]              sel_index;
    logic [14:0]             steering_next;
    logic [14:0]             motor_next;

    logic closing;
    logic advance;

    // Closing frame of a group needs room in the result register.
    assign closing  = (phase_reg == 2'd2);
    assign advance  = in_valid_reg && (!closing || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    assign phase_next = (phase_reg == 2'd1) ? 2'd2 : 2'd1;

    crchd_frame_update #(
        .NUM_COMMANDS(NUM_COMMANDS)
    ) u_frame_update (
        .phase             (phase_reg),
        .frame_data        (in_data_reg),
        .crc_cur           (crc_reg),
        .match_plain_cur   (match_plain_reg),
        .match_flipped_cur (match_flipped_reg),
        .crc_next          (crc_upd),
        .match_plain_next  (match_plain_upd),
        .match_flipped_next(match_flipped_upd)
    );

    crchd_cmd_select #(
        .NUM_COMMANDS(NUM_COMMANDS)
    ) u_cmd_select (
        .crc_final    (crc_upd),
        .match_plain  (match_plain_upd),
        .match_flipped(match_flipped_upd),
        .steering_hold(steering_hold_reg),
        .motor_hold   (motor_hold_reg),
        .status       (sel_status),
        .found        (sel_found),
        .index        (sel_index),
        .steering_next(steering_next),
        .motor_next   (motor_next)
    );

    // Input register: take a frame whenever the slot is free or draining.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_valid && !in_stall) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_data_reg <= frame_data;
    end

    // Running state and held pulses.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg         <= 2'd0;
            crc_reg           <= '0;
            match_plain_reg   <= MATCH_ALL;
            match_flipped_reg <= MATCH_ALL;
            steering_hold_reg <= PULSE_RESET;
            motor_hold_reg    <= PULSE_RESET;
        end else if (advance) begin
            if (closing) begin
                // Close the message: latch pulses, clear running state.
                phase_reg         <= 2'd0;
                crc_reg           <= '0;
                match_plain_reg   <= MATCH_ALL;
                match_flipped_reg <= MATCH_ALL;
                steering_hold_reg <= steering_next;
                motor_hold_reg    <= motor_next;
            end else begin
                phase_reg         <= phase_next;
                crc_reg           <= crc_upd;
                match_plain_reg   <= match_plain_upd;
                match_flipped_reg <= match_flipped_upd;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance && closing) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && closing) begin
            status_reg <= sel_status;
            found_reg  <= sel_found;
            index_reg  <= sel_index;
        end
    end

    assign out_valid      = out_valid_reg;
    assign check_status   = status_reg;
    assign command_found  = found_reg;
    assign command_index  = index_reg;
    assign steering_pulse = steering_hold_reg;
    assign motor_pulse    = motor_hold_reg;

endmodule
`default_nettype wire

// ----- src/crchd_frame_update.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// crchd_frame_update
// Folds one eight-byte frame into the running CRCs and match flags of both
// the plain and the inverted digest view.
// ---------------------------------------------------------------------------
module crchd_frame_update #(
    parameter int NUM_COMMANDS = crchd_pkg::NUM_COMMANDS_DEF
) (
    input  wire logic [1:0]              phase,
    input  wire logic [63:0]             frame_data,
    input  wire crchd_pkg::crc_pair_t    crc_cur,
    input  wire logic [NUM_COMMANDS-1:0] match_plain_cur,
    input  wire logic [NUM_COMMANDS-1:0] match_flipped_cur,
    output crchd_pkg::crc_pair_t         crc_next,
    output logic [NUM_COMMANDS-1:0]      match_plain_next,
    output logic [NUM_COMMANDS-1:0]      match_flipped_next
);
    import crchd_pkg::*;

    logic [1:0] phase_eff;

    // An unused phase code restarts the group.
    assign phase_eff = (phase == 2'd2) ? 2'd2 : ((phase == 2'd1) ? 2'd1 : 2'd0);

    always_comb
    begin
        logic [7:0]       b;
        logic [7:0]       nb;
        logic [POS_W-1:0] pos;
        crc_next           = crc_cur;
        match_plain_next   = match_plain_cur;
        match_flipped_next = match_flipped_cur;
        for (int i = 0; i < 8; i++) begin
            b   = frame_data[63 - 8*i -: 8];
            nb  = b ^ BYTE_INVERT;
            pos = {phase_eff, 3'b000} + POS_W'(i);
            if (pos < POS_W'(HASH_BYTES)) begin
                crc_next.plain   = crc_byte(crc_next.plain, b);
                crc_next.flipped = crc_byte(crc_next.flipped, nb);
                for (int k = 0; k < NUM_COMMANDS; k++) begin
                    if (cmd_hash_byte(ROW_W'(k), pos) != b)
                        match_plain_next[k] = 1'b0;
                    if (cmd_hash_byte(ROW_W'(k), pos) != nb)
                        match_flipped_next[k] = 1'b0;
                end
            end else if (pos < POS_W'(MESSAGE_BYTES)) begin
                // CRC bytes enter both views unchanged; trailing bytes drop.
                crc_next.plain   = crc_byte(crc_next.plain, b);
                crc_next.flipped = crc_byte(crc_next.flipped, b);
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/crchd_cmd_select.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// crchd_cmd_select
// Picks the passing CRC view, finds the first matching command and forms
// the next held pulse pair.
// ---------------------------------------------------------------------------
module crchd_cmd_select #(
    parameter int NUM_COMMANDS = crchd_pkg::NUM_COMMANDS_DEF
) (
    input  wire crchd_pkg::crc_pair_t    crc_final,
    input  wire logic [NUM_COMMANDS-1:0] match_plain,
    input  wire logic [NUM_COMMANDS-1:0] match_flipped,
    input  wire logic [14:0]             steering_hold,
    input  wire logic [14:0]             motor_hold,
    output crchd_pkg::status_t           status,
    output logic                         found,
    output logic [2:0]                   index,
    output logic [14:0]                  steering_next,
    output logic [14:0]                  motor_next
);
    import crchd_pkg::*;

    logic [NUM_COMMANDS-1:0] flags;
    logic [ROW_W-1:0]        sel_row;

    always_comb
    begin
        if (crc_final.plain == 16'h0000) begin
            status = STATUS_PLAIN;
            flags  = match_plain;
        end else if (crc_final.flipped == 16'h0000) begin
            status = STATUS_FLIPPED;
            flags  = match_flipped;
        end else begin
            status = STATUS_FAIL;
            flags  = '0;
        end
    end

    // Priority pick: scan down so the lowest set flag wins.
    always_comb
    begin
        found   = 1'b0;
        sel_row = '0;
        for (int k = NUM_COMMANDS - 1; k >= 0; k--) begin
            if (flags[k]) begin
                found   = 1'b1;
                sel_row = ROW_W'(k);
            end
        end
    end

    assign index         = sel_row[2:0];
    assign steering_next = found ? cmd_steer(sel_row) : steering_hold;
    assign motor_next    = found ? cmd_motor(sel_row) : motor_hold;

endmodule
`default_nettype wire
